>>> hdl/stable_insertion_sorter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable insertion sorter.
// Each macro wraps one clocked property with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef STABLE_INSERTION_SORTER_UNIT_ASSERT_SVH
`define STABLE_INSERTION_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication between two conditions.
`define SIS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorter assertion failed");

// Condition in one cycle implies a condition in the next.
`define SIS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorter assertion failed");

`endif

>>> hdl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants of the stable insertion sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sis_pkg;

  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int POS_BITS     = 10;
  localparam int SWAP_BITS    = 19;
  // Cells are grouped for the shift-count encoder.
  localparam int GROUP_BITS   = 6;
  localparam int GROUP_SIZE   = 1 << GROUP_BITS;

  localparam logic [SWAP_BITS-1:0] SWAP_MAX = '1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Command word.
  typedef struct packed {
    logic [1:0]              cmd;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } sis_req_t;

  // Result word.
  typedef struct packed {
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [POS_BITS-1:0]     arrival_position;
    logic                    last_record;
    logic                    empty_res;
    logic [SWAP_BITS-1:0]    swap_count;
    logic                    overflow;
  } sis_rsp_t;

  // One stored record.
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [POS_BITS-1:0]     pos;
  } sis_rec_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rd;
  } sis_ctl_t;

endpackage

>>> hdl/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted record chain. On an insert the cell either keeps its
// record, takes the new record, or takes its left neighbor's record. On a
// read it takes its right neighbor's record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_cell
  import sis_pkg::*;
(
  input  logic     clk,
  input  sis_ctl_t ctl,
  input  sis_rec_t new_rec,
  input  sis_rec_t left_rec,
  input  sis_rec_t right_rec,
  input  logic     occupied,
  input  logic     left_occupied,
  input  logic     left_gt,
  output logic     gt,
  output sis_rec_t rec
);

  // The stored key is strictly greater than the incoming key.
  assign gt = occupied && (rec.key > new_rec.key);

  // Shift right on insert, shift left on read.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_gt) begin
        rec <= left_rec;
      end else if (gt || (!occupied && left_occupied)) begin
        rec <= new_rec;
      end
    end else if (ctl.rd) begin
      rec <= right_rec;
    end
  end

endmodule

>>> hdl/sis_count.sv
// ----------------------------------------------------------------------------
// sis_count
// Shift counter. Encodes the insertion point from the one-hot boundary of the
// cell row in two registered stages, then adds the number of moved records to
// a saturating total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_count
  import sis_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 start,
  input  logic [DEPTH-1:0]     first_gt,
  input  logic [CNT_BITS-1:0]  occ,
  output logic [SWAP_BITS-1:0] swap_count,
  output logic                 busy
);

  localparam int NG      = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GI_BITS = (NG > 1) ? $clog2(NG) : 1;
  localparam int PAD     = NG * GROUP_SIZE;

  logic [PAD-1:0]        fg_pad;
  logic [NG-1:0]         grp_hit;
  logic [GROUP_BITS-1:0] grp_loc [NG];

  logic                  s1_valid;
  logic [NG-1:0]         s1_hit;
  logic [GROUP_BITS-1:0] s1_loc [NG];
  logic [CNT_BITS-1:0]   s1_occ;

  logic [GI_BITS-1:0]    gidx;
  logic [GROUP_BITS-1:0] lsel;
  logic                  any_hit;
  logic [GI_BITS+GROUP_BITS-1:0] pos;

  logic                  s2_valid;
  logic [CNT_BITS-1:0]   s2_moved;
  logic [SWAP_BITS:0]    sum;

  assign fg_pad = PAD'(first_gt);

  // First stage: per group, a hit flag and the local index of the hit.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit[g] = |fg_pad[g*GROUP_SIZE +: GROUP_SIZE];
      grp_loc[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (fg_pad[g*GROUP_SIZE + j]) begin
          grp_loc[g] = grp_loc[g] | GROUP_BITS'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_hit <= grp_hit;
    s1_loc <= grp_loc;
    s1_occ <= occ;
  end

  // Second stage: pick the hit group and form the insertion index.
  always_comb begin
    gidx    = '0;
    lsel    = '0;
    any_hit = 1'b0;
    for (int g = 0; g < NG; g++) begin
      if (s1_hit[g]) begin
        gidx    = gidx | GI_BITS'(g);
        lsel    = lsel | s1_loc[g];
        any_hit = 1'b1;
      end
    end
  end

  assign pos = {gidx, lsel};

  always_ff @(posedge clk) begin
    s2_moved <= any_hit ? (s1_occ - CNT_BITS'(pos)) : '0;
  end

  // Saturating accumulation of moved records.
  assign sum = {1'b0, swap_count} + (SWAP_BITS + 1)'(s2_moved);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      swap_count <= '0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      if (clear) begin
        swap_count <= '0;
      end else if (s2_valid) begin
        swap_count <= sum[SWAP_BITS] ? SWAP_MAX : sum[SWAP_BITS-1:0];
      end
    end
  end

  assign busy = s1_valid || s2_valid;

endmodule

>>> hdl/stable_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter_unit
// Stable ascending sorter built as a row of DEPTH record cells. An insert
// word (cmd 0) places the record after every stored record with a key less
// than or equal to its own and is written into the cell row on acceptance.
// A read word (cmd 1) returns the smallest record with last-record, empty,
// shift count and overflow status, loaded into the result register on
// acceptance. A clear word (cmd 2) empties the row and zeroes the counters;
// cmd 3 is ignored. Inserts can be taken every cycle; a read or clear that
// follows an insert waits until the two-stage shift-count encoder has
// drained. No word is taken while a result waits on a stalled output.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_insertion_sorter_unit
  import sis_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  sis_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output sis_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(DEPTH);
  localparam logic [CNT_BITS-1:0] ONE  = CNT_BITS'(1);

  logic [CNT_BITS-1:0]  occ;
  logic [POS_BITS-1:0]  arrival;
  logic                 overflow_flag;
  logic [SWAP_BITS-1:0] swap_count;
  logic                 busy;

  logic     accept;
  logic     ins_go;
  logic     rd_go;
  sis_ctl_t ctl;
  sis_rec_t new_rec;

  logic [DEPTH-1:0] gt_vec;
  logic [DEPTH-1:0] first_gt;
  logic [DEPTH-1:0] occ_vec;
  sis_rec_t         cell_rec [DEPTH];

  // Input handshake and command decode.
  assign req_stall = (rsp_valid && rsp_stall) || (busy && (req.cmd != CMD_INSERT));
  assign accept    = req_valid && !req_stall;
  assign ins_go    = accept && (req.cmd == CMD_INSERT) && (occ != FULL);
  assign rd_go     = accept && (req.cmd == CMD_READ) && (occ != '0);
  assign ctl.ins   = ins_go;
  assign ctl.rd    = rd_go;
  assign new_rec   = '{key: req.key, payload: req.payload, pos: arrival};

  // Row of record cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(i);
    logic     left_gt;
    logic     left_occ;
    sis_rec_t left_rec;
    sis_rec_t right_rec;

    assign occ_vec[i] = IDX < occ;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_occ = 1'b1;
      assign left_rec = new_rec;
    end else begin : g_mid
      assign left_gt  = gt_vec[i-1];
      assign left_occ = occ_vec[i-1];
      assign left_rec = cell_rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    assign first_gt[i] = gt_vec[i] && !left_gt;

    sis_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .new_rec       (new_rec),
      .left_rec      (left_rec),
      .right_rec     (right_rec),
      .occupied      (occ_vec[i]),
      .left_occupied (left_occ),
      .left_gt       (left_gt),
      .gt            (gt_vec[i]),
      .rec           (cell_rec[i])
    );
  end

  // Shift counter.
  sis_count #(
    .DEPTH (DEPTH)
  ) u_count (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept && (req.cmd == CMD_CLEAR)),
    .start      (ins_go),
    .first_gt   (first_gt),
    .occ        (occ),
    .swap_count (swap_count),
    .busy       (busy)
  );

  // Occupancy, arrival tag and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ           <= '0;
      arrival       <= '0;
      overflow_flag <= 1'b0;
    end else if (accept && (req.cmd == CMD_CLEAR)) begin
      occ           <= '0;
      arrival       <= '0;
      overflow_flag <= 1'b0;
    end else if (ins_go) begin
      occ     <= occ + ONE;
      arrival <= arrival + POS_BITS'(1);
    end else if (rd_go) begin
      occ <= occ - ONE;
    end else if (accept && (req.cmd == CMD_INSERT)) begin
      overflow_flag <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && (req.cmd == CMD_READ)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.cmd == CMD_READ)) begin
      rsp.swap_count <= swap_count;
      rsp.overflow   <= overflow_flag;
      if (occ == '0) begin
        rsp.out_key          <= '0;
        rsp.out_payload      <= '0;
        rsp.arrival_position <= '0;
        rsp.last_record      <= 1'b0;
        rsp.empty_res        <= 1'b1;
      end else begin
        rsp.out_key          <= cell_rec[0].key;
        rsp.out_payload      <= cell_rec[0].payload;
        rsp.arrival_position <= cell_rec[0].pos;
        rsp.last_record      <= (occ == ONE);
        rsp.empty_res        <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/sis_check.sv
// ----------------------------------------------------------------------------
// sis_check
// Port-level checks of the stable insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_insertion_sorter_unit_assert.svh"

module sis_check
  import sis_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input sis_req_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input sis_rsp_t rsp
);

  // A stalled result word holds.
  `SIS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Every accepted read word gives a result word in the next cycle.
  `SIS_ASSERT_NEXT(a_read_answers, clk, rst, req_valid && !req_stall && req.cmd == CMD_READ, rsp_valid)

  // An empty result carries no record.
  `SIS_ASSERT_IMPLY(a_empty_zero, clk, rst, rsp_valid && rsp.empty_res, rsp.out_key == '0 && rsp.out_payload == '0 && rsp.arrival_position == '0 && !rsp.last_record)

  // While a result waits, no new word is taken.
  `SIS_ASSERT_IMPLY(a_backpressure, clk, rst, rsp_valid && rsp_stall, req_stall)

endmodule

bind stable_insertion_sorter_unit sis_check u_check (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_insertion_sorter_unit. Command words go in
// through a valid/stall port. Each accepted word updates a local sorted-record
// model, and each read pushes the word that the model expects. A checker
// compares every returned result word, field by field, in order. The tests
// cover the edge cases, random insert/read bursts with many tied keys, a fill
// past capacity that saturates the shift counter and wraps the arrival tags,
// and long output back-pressure. The run ends with a stretch of full-rate
// traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sis_pkg::*;

  localparam int         STORE_DEPTH = 1024;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         TAIL_CYCLES = 20;
  localparam int         LONG_HOLD   = 300;

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  sis_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  sis_rsp_t rsp;

  // Local copy of the sorter state.
  sis_rec_t            sorted_recs[$];
  logic [POS_BITS-1:0] arrival_ctr   = '0;
  int unsigned         shift_total   = 0;
  logic                overflow_seen = 1'b0;

  // Result words still owed by the block, oldest first.
  sis_rsp_t pending_rsp[$];

  int err_count   = 0;
  int cycle_count = 0;
  bit send_idle_en = 1'b1;
  bit rcv_idle_en  = 1'b1;
  int hold_cycles  = 0;

  stable_insertion_sorter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A run that hangs is stopped here.
  initial begin
    wait (cycle_count > CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one accepted command word to the local sorter and record the
  // result word that a read is owed.
  function automatic void sorter_apply(sis_req_t w);
    int       slot;
    int       moved;
    sis_rsp_t r;
    case (w.cmd)
      CMD_INSERT: begin
        if (sorted_recs.size() >= STORE_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          // Equal keys stay in arrival order: skip every key <= the new one.
          slot = 0;
          while (slot < sorted_recs.size() && sorted_recs[slot].key <= w.key) slot++;
          moved = sorted_recs.size() - slot;
          sorted_recs.insert(slot, '{key: w.key, payload: w.payload, pos: arrival_ctr});
          arrival_ctr = arrival_ctr + 1'b1;
          if (shift_total + moved >= SWAP_MAX) shift_total = SWAP_MAX;
          else shift_total = shift_total + moved;
        end
      end
      CMD_READ: begin
        r = '0;
        r.swap_count = SWAP_BITS'(shift_total);
        r.overflow   = overflow_seen;
        if (sorted_recs.size() == 0) begin
          r.empty_res = 1'b1;
        end else begin
          r.out_key          = sorted_recs[0].key;
          r.out_payload      = sorted_recs[0].payload;
          r.arrival_position = sorted_recs[0].pos;
          void'(sorted_recs.pop_front());
          r.last_record      = (sorted_recs.size() == 0);
        end
        pending_rsp.push_back(r);
      end
      CMD_CLEAR: begin
        sorted_recs.delete();
        arrival_ctr   = '0;
        shift_total   = 0;
        overflow_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Sends one command word, with an occasional idle burst ahead of it.
  // The valid is left high so that back-to-back words need no re-raise.
  task automatic send_word(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                           input logic [PAYLOAD_BITS-1:0] p);
    sis_req_t w;
    bit       taken;
    w.cmd     = op;
    w.key     = k;
    w.payload = p;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    // Stall is stable by the falling edge; the word moves at the next rising edge.
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    sorter_apply(w);
  endtask

  // Drops valid and waits until every owed result word has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Keys lean toward a narrow range so that ties are common.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_BITS'($urandom_range(0, 7));
      1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Output side: random stall bursts, plus a long hold when one is requested.
  initial begin
    int burst_left;
    bit stall_next;
    burst_left = 0;
    forever begin
      @(posedge clk);
      stall_next = 1'b0;
      if (hold_cycles > 0) begin
        stall_next = 1'b1;
        hold_cycles--;
      end else if (rcv_idle_en && burst_left > 0) begin
        stall_next = 1'b1;
        burst_left--;
      end else if (rcv_idle_en && $urandom_range(0, 7) == 0) begin
        stall_next = 1'b1;
        burst_left = $urandom_range(1, 16) - 1;
      end
      rsp_stall <= stall_next;
    end
  end

  // Result checker: the word is taken at the next rising edge, so sample now.
  initial begin
    sis_rsp_t want;
    forever begin
      @(negedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("result word with none owed, key", rsp.out_key, 0);
        end else begin
          want = pending_rsp.pop_front();
          check_field("out_key", rsp.out_key, want.out_key);
          check_field("out_payload", rsp.out_payload, want.out_payload);
          check_field("arrival_position", rsp.arrival_position, want.arrival_position);
          check_field("last_record", rsp.last_record, want.last_record);
          check_field("empty_res", rsp.empty_res, want.empty_res);
          check_field("swap_count", rsp.swap_count, want.swap_count);
          check_field("overflow", rsp.overflow, want.overflow);
        end
      end
    end
  end

  // Edge cases: empty reads, key and payload extremes, ties, the unused
  // command, emptying the store and clearing the counters.
  task automatic test_directed();
    send_word(CMD_READ, '1, '1);
    send_word(CMD_INSERT, 16'd5, 32'h0000_00A1);
    send_word(CMD_INSERT, 16'd5, 32'h0000_00B2);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_INSERT, 16'd5, 32'h0000_00C3);
    send_word(CMD_UNUSED, 16'd1, 32'h1);
    repeat (5) send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
    send_word(CMD_READ, '0, '0);
    send_word(CMD_INSERT, 16'd3, 32'h5555_5555);
    send_word(CMD_INSERT, 16'd1, 32'hAAAA_AAAA);
    send_word(CMD_CLEAR, KEY_BITS'($urandom), $urandom);
    send_word(CMD_READ, '1, '0);
    send_word(CMD_INSERT, '1, 32'h8000_0001);
    send_word(CMD_READ, '0, '1);
    wait_drained();
  endtask

  // Random bursts of inserts followed by reads, with some clears, ignored
  // words and full pauses mixed in.
  task automatic test_random_mix(int n_items);
    int sent;
    int ins_n;
    int rd_n;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0: begin
          send_word(CMD_CLEAR, KEY_BITS'($urandom), $urandom);
          sent++;
        end
        1: send_word(CMD_UNUSED, KEY_BITS'($urandom), $urandom);
        2: if (send_idle_en) wait_drained();
        default: begin
          ins_n = $urandom_range(1, 24);
          rd_n  = $urandom_range(1, ins_n + 2);
          repeat (ins_n) send_word(CMD_INSERT, pick_key(), $urandom);
          repeat (rd_n) send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
          sent += ins_n + rd_n;
        end
      endcase
    end
  endtask

  // Fill the store with falling keys so every insert shifts the whole row,
  // overrun it, then insert more to saturate the shift count and wrap the
  // arrival tags.
  task automatic test_fill_overflow();
    send_word(CMD_CLEAR, KEY_BITS'($urandom), $urandom);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_word(CMD_INSERT, KEY_BITS'(65535 - i * 64 - $urandom_range(0, 63)), $urandom);
    end
    repeat (3) send_word(CMD_INSERT, pick_key(), $urandom);
    repeat (8) send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
    repeat (8) send_word(CMD_INSERT, '0, $urandom);
    repeat (12) send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
    send_word(CMD_CLEAR, KEY_BITS'($urandom), $urandom);
    send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    hold_cycles = LONG_HOLD;
    repeat (40) begin
      if ($urandom_range(0, 1) != 0) send_word(CMD_READ, KEY_BITS'($urandom), $urandom);
      else send_word(CMD_INSERT, pick_key(), $urandom);
    end
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    send_idle_en = 1'b0;
    rcv_idle_en  = 1'b0;
    test_random_mix(150);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(580);
    test_fill_overflow();
    test_backpressure();
    test_full_rate();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) report_mismatch("result words never returned",
                                                 0, pending_rsp.size());
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> stable_insertion_sorter_unit.f
+incdir+hdl
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/sis_count.sv
hdl/stable_insertion_sorter_unit.sv
hdl/sis_check.sv
test/tb_top.sv
